// ===== sv/rfcc_pkg.sv =====
// ----------------------------------------------------------------------------
// rfcc_pkg
// Shared types, status codes and the CRC-16 byte step for the RTU frame
// checker.
// ----------------------------------------------------------------------------
package rfcc_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_IGNORED   = 3'd1,
    ST_BAD_CRC   = 3'd2,
    ST_TOO_SHORT = 3'd3,
    ST_TOO_LONG  = 3'd4
  } rfcc_status_t;

  localparam int unsigned LEN_W = 9;

  // Reflected CRC-16/MODBUS polynomial and start value
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // One verdict for a finished frame
  typedef struct packed {
    rfcc_status_t     status;
    logic [LEN_W-1:0] frame_length;
  } rfcc_result_t;

  // Advance the CRC by one byte, LSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== sv/rtu_frame_crc_checker.sv =====
// ----------------------------------------------------------------------------
// rtu_frame_crc_checker
// The verdict appears on out_valid in the cycle after the item with
// frame_end is accepted. Bytes are taken one per cycle while the result
// register is empty or being read; a waiting result stalls the input.
// Reset (rst, synchronous): clears frame state, empties the result register,
// own address returns to 1.
// ----------------------------------------------------------------------------
module rtu_frame_crc_checker
  import rfcc_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       data_byte,
  input  logic             frame_end,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       status,
  output logic [LEN_W-1:0] frame_length,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [7:0]       cfg_data
);

  logic [7:0]   own_address;
  logic         accept;
  logic         result_load;
  rfcc_result_t result;
  rfcc_result_t held;

  // Own address register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= 8'h01;
    end else if (cfg_valid && cfg_ready) begin
      own_address <= cfg_data;
    end
  end

  assign accept = in_valid && in_ready;

  rfcc_frame_track #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_track (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .data_byte   (data_byte),
    .frame_end   (frame_end),
    .own_address (own_address),
    .result_load (result_load),
    .result      (result)
  );

  rfcc_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (result_load),
    .result    (result),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .held      (held),
    .slot_free (in_ready)
  );

  assign status       = held.status;
  assign frame_length = held.frame_length;

endmodule

// ===== sv/rfcc_frame_track.sv =====
// ----------------------------------------------------------------------------
// rfcc_frame_track
// Per-frame state: byte count, address match, two-byte CRC delay line and
// running CRC. Produces a verdict on the item that ends a frame.
// ----------------------------------------------------------------------------
module rfcc_frame_track
  import rfcc_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = 256
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         accept,
  input  logic [7:0]   data_byte,
  input  logic         frame_end,
  input  logic [7:0]   own_address,
  output logic         result_load,
  output rfcc_result_t result
);

  // Count saturates at MAX_FRAME_BYTES + 1
  localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 2);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_BYTES);

  logic [15:0]      crc;          // natural (unswapped) CRC value
  logic [7:0]       held0;        // older of the two held bytes
  logic [7:0]       held1;
  logic [CNT_W-1:0] byte_count;
  logic             mismatch;

  logic [15:0]      crc_next;
  logic [CNT_W-1:0] count_next;
  logic             mismatch_next;
  logic [CNT_W-1:0] len_sat;

  // Next-state values for this byte
  always_comb begin
    mismatch_next = (byte_count == '0)
                  ? ((data_byte != own_address) && (data_byte != 8'h00))
                  : mismatch;
    crc_next   = (byte_count >= CNT_W'(2)) ? crc_byte(crc, held0) : crc;
    count_next = (byte_count <= CNT_MAX) ? byte_count + CNT_W'(1) : byte_count;
    len_sat    = (count_next > CNT_MAX) ? CNT_MAX : count_next;
  end

  // Verdict, by precedence: ignored, short, long, CRC
  always_comb begin
    result_load         = accept && frame_end;
    result.frame_length = LEN_W'(len_sat);
    if (mismatch_next) begin
      result.status = ST_IGNORED;
    end else if (count_next < CNT_W'(3)) begin
      result.status = ST_TOO_SHORT;
    end else if (count_next > CNT_MAX) begin
      result.status = ST_TOO_LONG;
    end else if (crc_next == {data_byte, held1}) begin
      result.status = ST_ACCEPTED;
    end else begin
      result.status = ST_BAD_CRC;
    end
  end

  // State update; frame end returns everything to the start values
  always_ff @(posedge clk) begin
    if (rst || (accept && frame_end)) begin
      crc        <= CRC_INIT;
      held0      <= 8'h00;
      held1      <= 8'h00;
      byte_count <= '0;
      mismatch   <= 1'b0;
    end else if (accept) begin
      crc        <= crc_next;
      held0      <= held1;
      held1      <= data_byte;
      byte_count <= count_next;
      mismatch   <= mismatch_next;
    end
  end

endmodule

// ===== sv/rfcc_out_reg.sv =====
// ----------------------------------------------------------------------------
// rfcc_out_reg
// Result register toward the output channel; frees the input side whenever
// the slot is empty or being taken.
// ----------------------------------------------------------------------------
module rfcc_out_reg
  import rfcc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  rfcc_result_t result,
  input  logic         out_ready,
  output logic         out_valid,
  output rfcc_result_t held,
  output logic         slot_free
);

  assign slot_free = !out_valid || out_ready;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

endmodule

// ===== sv/rfcc_checker.sv =====
// ----------------------------------------------------------------------------
// rfcc_checker
// Port-level checks on the RTU frame checker, bound to the top level.
// ----------------------------------------------------------------------------
module rfcc_checker
  import rfcc_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic [7:0]       data_byte,
  input logic             frame_end,
  input logic             out_valid,
  input logic             out_ready,
  input logic [2:0]       status,
  input logic [LEN_W-1:0] frame_length,
  input logic             cfg_valid,
  input logic             cfg_ready,
  input logic [7:0]       cfg_data
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(frame_length))
    else $error("result changed while stalled");

  // A frame end item yields a result in the next cycle
  a_end_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && frame_end |=> out_valid)
    else $error("no result after frame end");

  // Input stalls only behind a waiting result
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with free result slot");

  // A short verdict carries a length of one or two
  a_short_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_TOO_SHORT |-> frame_length == 9'd1 || frame_length == 9'd2)
    else $error("short frame with bad length");

endmodule

bind rtu_frame_crc_checker rfcc_checker u_rfcc_checker (.*);

// ===== tb/tb_rtu_frame_crc_checker.sv =====
// ----------------------------------------------------------------------------
// tb_rtu_frame_crc_checker
// Self-checking bench for the RTU frame checker. A short table of hand-picked
// bytes comes first, then random frames under several own-address settings.
// Most random frames carry a valid CRC-16 trailer, and most an own or
// broadcast address; the rest are short, corrupted or addressed elsewhere.
// A bench model of the frame state predicts each verdict, checked in order.
// ----------------------------------------------------------------------------
module tb_rtu_frame_crc_checker;
  timeunit 1ns;
  timeprecision 1ps;

  import rfcc_pkg::*;

  localparam int unsigned MAX_BYTES = 256;
  localparam int IDLE_PCT    = 17;
  localparam int STALL_LIMIT = 2000;
  localparam int N_DIRECTED  = 21;
  localparam int N_PHASES    = 5;
  localparam int PHASE_BYTES = 30;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  logic [7:0]       data_byte;
  logic             frame_end;
  logic             out_valid;
  logic             out_ready;
  logic [2:0]       status;
  logic [LEN_W-1:0] frame_length;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [7:0]       cfg_data;

  rtu_frame_crc_checker dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .frame_end    (frame_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .frame_length (frame_length),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  // Expected verdict of one frame
  typedef struct packed {
    rfcc_status_t     st;
    logic [LEN_W-1:0] len;
  } verdict_t;

  // One row of the directed table; the verdict is only used when typed is set
  typedef struct packed {
    logic [7:0]       b;
    logic             last;
    logic             typed;
    rfcc_status_t     st;
    logic [LEN_W-1:0] len;
  } dir_row_t;

  verdict_t verdict_q[$];
  verdict_t head_v;
  dir_row_t dir_rows[N_DIRECTED];
  int       errors = 0;
  bit       idle_on = 1'b1;

  // Frame state as the bench sees it
  logic [7:0]       own_addr_m;
  logic [15:0]      crc_m;
  logic [7:0]       held_m[2];
  logic [LEN_W-1:0] count_m;
  logic             mismatch_m;

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // CRC-16/MODBUS, one byte, bit by bit, natural order (low byte sent first)
  function automatic logic [15:0] crc16_update(logic [15:0] c, logic [7:0] b);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  task automatic frame_clear();
    crc_m      = CRC_INIT;
    held_m[0]  = 8'h00;
    held_m[1]  = 8'h00;
    count_m    = '0;
    mismatch_m = 1'b0;
  endtask

  // Advance the frame state by one byte; done is set on a frame end
  task automatic frame_predict(input logic [7:0] b, input logic last,
                               output logic done, output verdict_t v);
    done = 1'b0;
    v = '0;
    if (count_m == 0) begin
      mismatch_m = (b != own_addr_m) && (b != 8'h00);
    end
    // The two newest bytes wait in the delay, older ones go into the CRC
    if (count_m >= 2) begin
      crc_m = crc16_update(crc_m, held_m[0]);
    end
    held_m[0] = held_m[1];
    held_m[1] = b;
    if (count_m <= MAX_BYTES) begin
      count_m = count_m + 1'b1;
    end
    if (last) begin
      v.len = (count_m > MAX_BYTES) ? LEN_W'(MAX_BYTES) : count_m;
      if (mismatch_m) begin
        v.st = ST_IGNORED;
      end else if (count_m < 3) begin
        v.st = ST_TOO_SHORT;
      end else if (count_m > MAX_BYTES) begin
        v.st = ST_TOO_LONG;
      end else if ({held_m[1], held_m[0]} == crc_m) begin
        v.st = ST_ACCEPTED;
      end else begin
        v.st = ST_BAD_CRC;
      end
      done = 1'b1;
      frame_clear();
    end
  endtask

  // Offer one byte, wait for the handshake, then record what it should cause
  task automatic send_byte(input logic [7:0] b, input logic last,
                           input logic typed, input verdict_t typed_v);
    logic     done;
    verdict_t v;
    while (idle_on && ($urandom_range(99) < IDLE_PCT)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    frame_end <= last;
    // ready is stable from the falling edge to the next rising edge
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    frame_predict(b, last, done, v);
    if (done) begin
      verdict_q.push_back(typed ? typed_v : v);
    end
  endtask

  // Hold the sender until every expected verdict is out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_own_address(input logic [7:0] a);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= a;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    own_addr_m = a;
    cfg_valid <= 1'b0;
  endtask

  // Build one frame of n bytes; with n >= 3 the last two are the CRC,
  // spoiled in one random byte unless good is set
  task automatic send_frame(input int n, input logic [7:0] addr, input bit good);
    logic [7:0]  fb[$];
    logic [15:0] c;
    int          pos;
    fb.push_back(addr);
    if (n < 3) begin
      for (int i = 1; i < n; i++) fb.push_back(8'($urandom));
    end else begin
      for (int i = 1; i < n - 2; i++) fb.push_back(8'($urandom));
      c = CRC_INIT;
      foreach (fb[i]) c = crc16_update(c, fb[i]);
      fb.push_back(c[7:0]);
      fb.push_back(c[15:8]);
      if (!good) begin
        pos = $urandom_range(n - 1);
        fb[pos] = fb[pos] ^ 8'($urandom_range(255, 1));
      end
    end
    foreach (fb[i]) send_byte(fb[i], i == n - 1, 1'b0, verdict_t'(0));
  endtask

  // Random frame: mostly short and well formed, some noise
  task automatic send_rand_frame(output int n);
    int         r;
    logic [7:0] addr;
    r = $urandom_range(99);
    if (r < 6) begin
      n = $urandom_range(2, 1);
    end else if (r < 94) begin
      n = $urandom_range(12, 3);
    end else begin
      n = $urandom_range(40, 13);
    end
    r = $urandom_range(99);
    if (r < 45) begin
      addr = own_addr_m;
    end else if (r < 65) begin
      addr = 8'h00;
    end else begin
      addr = 8'($urandom_range(255));
    end
    send_frame(n, addr, $urandom_range(99) < 75);
  endtask

  // Receiver: random back-pressure
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Result check, sampled at the falling edge ahead of the accepting edge
  always @(negedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d length %0d",
                 $time, status, frame_length);
        errors++;
      end else begin
        head_v = verdict_q.pop_front();
        if (status !== head_v.st) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, head_v.st, status);
          errors++;
        end
        if (frame_length !== head_v.len) begin
          $display("%0t: frame_length mismatch, expected %0d, actual %0d",
                   $time, head_v.len, frame_length);
          errors++;
        end
      end
    end
  end

  // Watchdog: cycles in a row with no handshake on any channel
  logic moved = 1'b0;
  int   stall_cycles = 0;

  always @(negedge clk) begin
    moved <= (in_valid && in_ready) || (out_valid && out_ready) ||
             (cfg_valid && cfg_ready);
  end

  always @(posedge clk) begin
    if (moved) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    logic [7:0] phase_addr[N_PHASES];
    verdict_t   tv;
    int         nbytes;
    int         nframes;
    int         n;

    rst       <= 1'b1;
    in_valid  <= 1'b0;
    data_byte <= 8'h00;
    frame_end <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= 8'h00;
    own_addr_m = 8'd1;
    frame_clear();

    // Byte, end mark, typed, status, length
    dir_rows = '{
      // single address byte
      '{8'h01, 1'b1, 1'b1, ST_TOO_SHORT, 9'd1},
      // broadcast, two bytes
      '{8'h00, 1'b0, 1'b0, ST_ACCEPTED,  9'd0},
      '{8'hAB, 1'b1, 1'b1, ST_TOO_SHORT, 9'd2},
      // foreign address, one byte
      '{8'h05, 1'b1, 1'b1, ST_IGNORED,   9'd1},
      // read request with a valid trailer
      '{8'h01, 1'b0, 1'b0, ST_ACCEPTED,  9'd0},
      '{8'h03, 1'b0, 1'b0, ST_ACCEPTED,  9'd0},
      '{8'h00, 1'b0, 1'b0, ST_ACCEPTED,  9'd0},
      '{8'h00, 1'b0, 1'b0, ST_ACCEPTED,  9'd0},
      '{8'h00, 1'b0, 1'b0, ST_ACCEPTED,  9'd0},
      '{8'h01, 1'b0, 1'b0, ST_ACCEPTED,  9'd0},
      '{8'h84, 1'b0, 1'b0, ST_ACCEPTED,  9'd0},
      '{8'h0A, 1'b1, 1'b0, ST_ACCEPTED,  9'd0},
      // shortest judged frame, all-ones trailer
      '{8'h01, 1'b0, 1'b0, ST_ACCEPTED,  9'd0},
      '{8'hFF, 1'b0, 1'b0, ST_ACCEPTED,  9'd0},
      '{8'hFF, 1'b1, 1'b0, ST_ACCEPTED,  9'd0},
      // top address value, not ours
      '{8'hFF, 1'b0, 1'b0, ST_ACCEPTED,  9'd0},
      '{8'h00, 1'b1, 1'b1, ST_IGNORED,   9'd2},
      // broadcast with an arbitrary trailer
      '{8'h00, 1'b0, 1'b0, ST_ACCEPTED,  9'd0},
      '{8'h12, 1'b0, 1'b0, ST_ACCEPTED,  9'd0},
      '{8'h34, 1'b0, 1'b0, ST_ACCEPTED,  9'd0},
      '{8'h56, 1'b1, 1'b0, ST_ACCEPTED,  9'd0}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed table under the reset address
    for (int i = 0; i < N_DIRECTED; i++) begin
      tv.st  = dir_rows[i].st;
      tv.len = dir_rows[i].len;
      send_byte(dir_rows[i].b, dir_rows[i].last, dir_rows[i].typed, tv);
    end

    // Random frames; one phase per own-address setting
    phase_addr = '{8'd1, 8'd0, 8'd247, 8'd255, 8'($urandom_range(255))};
    for (int p = 0; p < N_PHASES; p++) begin
      if (p > 0) begin
        write_own_address(phase_addr[p]);
      end
      idle_on = (p != 1);
      // longest frame still judged, then the first one past the limit
      if (p == 2) begin
        send_frame(MAX_BYTES, own_addr_m, 1'b1);
      end
      if (p == 3) begin
        send_frame(MAX_BYTES + 1, own_addr_m, 1'b1);
      end
      nbytes = 0;
      nframes = 0;
      while (nbytes < PHASE_BYTES) begin
        send_rand_frame(n);
        nbytes += n;
        nframes++;
        if (nframes == 3) begin
          wait_drained();
        end
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/rfcc_pkg.sv
sv/rfcc_frame_track.sv
sv/rfcc_out_reg.sv
sv/rtu_frame_crc_checker.sv
sv/rfcc_checker.sv
tb/tb_rtu_frame_crc_checker.sv
